// ===== rtl/core/huffman_tree_builder_assert.svh =====
// Assertion macros shared by the Huffman tree builder RTL.
// Included by the controller and datapath files; no other dependencies.
`ifndef HUFFMAN_TREE_BUILDER_ASSERT_SVH
`define HUFFMAN_TREE_BUILDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTB_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("huffman tree builder: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HTB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("huffman tree builder: assertion failed");

`endif

// ===== rtl/core/htb_pkg.sv =====
// Shared types and constants of the Huffman tree builder.
// Used by the channel interfaces, the controller, the datapath and the top level.
package htb_pkg;

   // Field widths of the request and response transactions.
   localparam int COUNT_W  = 40;
   localparam int WEIGHT_W = 50;
   localparam int LEAF_W   = 8;
   localparam int DEPTH_W  = 8;
   localparam int PNODE_W  = 8;
   localparam int LEN_W    = 8;

   // Request command codes.
   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } req_cmd_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_FETCH0,
      ST_PICK0,
      ST_FETCH1,
      ST_PICK1,
      ST_WALK,
      ST_REPLY
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic build_init;
      logic fetch;
      logic pick;
      logic pick_second;
      logic set_built;
      logic query_start;
      logic walk;
      logic rsp_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic n_zero;
      logic n_one;
      logic tree_built;
      logic query_walk;
      logic last_node;
      logic walk_done;
   } dp_status_type;

endpackage

// ===== rtl/core/htb_req_if.sv =====
// Request channel of the Huffman tree builder: valid/ready plus load and query fields.
// Depends on htb_pkg for the field widths.
interface htb_req_if import htb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [COUNT_W-1:0]   leaf_count;
   logic                 last;
   logic [LEAF_W-1:0]    leaf;
   logic [DEPTH_W-1:0]   depth;

   modport source (output valid, cmd, leaf_count, last, leaf, depth, input ready);
   modport sink   (input valid, cmd, leaf_count, last, leaf, depth, output ready);
endinterface

// ===== rtl/core/htb_rsp_if.sv =====
// Response channel of the Huffman tree builder: valid/ready plus the path query result.
// Depends on htb_pkg for the field widths.
interface htb_rsp_if import htb_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [PNODE_W-1:0]   path_node;
   logic                 code_bit;
   logic [LEN_W-1:0]     path_length;
   logic                 depth_ok;

   modport source (output valid, path_node, code_bit, path_length, depth_ok, input ready);
   modport sink   (input valid, path_node, code_bit, path_length, depth_ok, output ready);
endinterface

// ===== rtl/core/htb_ctrl.sv =====
// Controller state machine of the Huffman tree builder.
// Sequences loads, the two-queue build and path walks; depends on htb_pkg and the assert macros.
`include "huffman_tree_builder_assert.svh"

module htb_ctrl import htb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_cmd,
   input  logic          req_last,
   output logic          req_ready,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   // A new transaction is taken only between operations.
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_LOAD) begin
                  if (req_last) state_in = ST_START;
               end else begin
                  state_in = status.query_walk ? ST_WALK : ST_REPLY;
               end
            end
         end
         ST_START: begin
            if (status.n_zero || status.n_one) state_in = ST_IDLE;
            else state_in = ST_FETCH0;
         end
         ST_FETCH0: state_in = ST_PICK0;
         ST_PICK0:  state_in = ST_FETCH1;
         ST_FETCH1: state_in = ST_PICK1;
         ST_PICK1: begin
            state_in = status.last_node ? ST_IDLE : ST_FETCH0;
         end
         ST_WALK: begin
            if (status.walk_done) state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load        = req_valid && (req_cmd == CMD_LOAD);
            cmd.query_start = req_valid && (req_cmd == CMD_QUERY);
         end
         ST_START: begin
            cmd.set_built  = status.n_one;
            cmd.build_init = !status.n_zero && !status.n_one;
         end
         ST_FETCH0: cmd.fetch = 1'b1;
         ST_PICK0:  cmd.pick  = 1'b1;
         ST_FETCH1: cmd.fetch = 1'b1;
         ST_PICK1: begin
            cmd.pick        = 1'b1;
            cmd.pick_second = 1'b1;
            cmd.set_built   = status.last_node;
         end
         ST_WALK:  cmd.walk     = 1'b1;
         ST_REPLY: cmd.rsp_load = rsp_free;
         default:  cmd = '0;
      endcase
   end

   // The response register is full from its load until the sink takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A loaded reply is offered on the next cycle.
   `HTB_ASSERT_NEXT(a_reply_sets_valid, clock, reset, cmd.rsp_load, rsp_valid_ff)
   // Walks only run over a finished tree.
   `HTB_ASSERT_IMPLY(a_walk_needs_tree, clock, reset, state_ff == ST_WALK, status.tree_built)
   // Merging only happens with at least two leaves.
   `HTB_ASSERT_IMPLY(a_build_needs_two, clock, reset, state_ff == ST_FETCH0, !status.n_zero && !status.n_one)

endmodule

// ===== rtl/core/htb_dp.sv =====
// Datapath of the Huffman tree builder: leaf, node-weight and parent memories,
// queue pointers, saturating adder and path walker; depends on htb_pkg and the assert macros.
`include "huffman_tree_builder_assert.svh"

module htb_dp import htb_pkg::*; #(
   parameter int MAX_LEAVES = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   input  logic [COUNT_W-1:0]   req_leaf_count,
   input  logic [LEAF_W-1:0]    req_leaf,
   input  logic [DEPTH_W-1:0]   req_depth,
   output logic [PNODE_W-1:0]   rsp_path_node,
   output logic                 rsp_code_bit,
   output logic [LEN_W-1:0]     rsp_path_length,
   output logic                 rsp_depth_ok
);

   localparam int LW = $clog2(MAX_LEAVES);
   localparam int NW = LW + 1;
   localparam int CW = (NW > 8) ? NW : 8;
   localparam int NODE_TOTAL = 2 * MAX_LEAVES - 1;

   // Memories: leaf counts, internal node weights, and {code bit, parent id} per node.
   logic [COUNT_W-1:0]  leaf_mem   [MAX_LEAVES];
   logic [WEIGHT_W-1:0] int_mem    [MAX_LEAVES-1];
   logic [NW:0]         parent_mem [NODE_TOTAL];

   // Control registers.
   logic [NW-1:0] n_ff, n_in;
   logic          built_ff, built_in;

   // Build and walk registers.
   logic [NW-1:0]       lf_left_ff, lf_left_in;
   logic [LW-1:0]       nd_rel_ff, nd_rel_in;
   logic [LW-1:0]       i_rel_ff, i_rel_in;
   logic [WEIGHT_W-1:0] pick_w_ff, pick_w_in;
   logic [COUNT_W-1:0]  leaf_rd_ff;
   logic [WEIGHT_W-1:0] int_rd_ff;
   logic [NW:0]         parent_rd_ff;
   logic [NW-1:0]       steps_ff, steps_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [PNODE_W-1:0]  pnode_ff, pnode_in;
   logic                pcode_ff, pcode_in;
   logic                found_ff, found_in;

   // Response payload register.
   logic [PNODE_W-1:0]  rsp_path_node_ff;
   logic                rsp_code_bit_ff;
   logic [LEN_W-1:0]    rsp_path_length_ff;
   logic                rsp_depth_ok_ff;

   // Combinational terms.
   logic [CW-1:0]       leaf_ext, n_ext, steps_ext, pnode_ext;
   logic [NW-1:0]       root_id, node_id, nd_id, lf_id, pick_id;
   logic [NW-1:0]       load_idx, walk_p, pnode_diff, parent_addr;
   logic                load_ok, take_leaf, walk_code, step_hit, parent_rd_en;
   logic [WEIGHT_W-1:0] leaf_w, pick_w, sum_sat;
   logic [WEIGHT_W:0]   sum_full;

   // Tree shape: the root is node 2n-2, internal node k is node n+k.
   assign leaf_ext = CW'(req_leaf);
   assign n_ext    = CW'(n_ff);
   assign root_id  = NW'({n_ff, 1'b0} - (NW+1)'(2));
   assign node_id  = n_ff + NW'(i_rel_ff);
   assign nd_id    = n_ff + NW'(nd_rel_ff);
   assign lf_id    = lf_left_ff - NW'(1);

   // Load slot: a load after a finished build restarts at leaf zero.
   assign load_idx = built_ff ? '0 : n_ff;
   assign load_ok  = built_ff || (n_ff < NW'(MAX_LEAVES));

   // Queue selection: while leaves remain, the leaf wins only when strictly lighter, and always
   // when the node queue has caught up with the node being built.
   assign leaf_w    = WEIGHT_W'(leaf_rd_ff);
   assign take_leaf = (lf_left_ff != '0) && ((nd_rel_ff == i_rel_ff) || (leaf_w < int_rd_ff));
   assign pick_w    = take_leaf ? leaf_w : int_rd_ff;
   assign pick_id   = take_leaf ? lf_id : nd_id;

   // Saturating sum of the two children.
   assign sum_full = {1'b0, pick_w_ff} + {1'b0, pick_w};
   assign sum_sat  = sum_full[WEIGHT_W] ? '1 : sum_full[WEIGHT_W-1:0];

   // Path walk terms.
   assign walk_p      = parent_rd_ff[NW-1:0];
   assign walk_code   = parent_rd_ff[NW];
   assign steps_ext   = CW'(steps_ff);
   assign step_hit    = (steps_ext == CW'(depth_ff));
   assign pnode_diff  = walk_p - n_ff;
   assign pnode_ext   = CW'(pnode_diff);
   assign parent_addr = cmd.walk ? walk_p : leaf_ext[NW-1:0];

   // Status to the controller.
   assign status.n_zero     = (n_ff == '0);
   assign status.n_one      = (n_ff == NW'(1));
   assign status.tree_built = built_ff;
   assign status.query_walk = built_ff && (leaf_ext < n_ext) && (n_ff != NW'(1));
   assign status.last_node  = (i_rel_ff == LW'(n_ff - NW'(2)));
   assign status.walk_done  = (walk_p == root_id);

   assign parent_rd_en = (cmd.walk && !status.walk_done) || (cmd.query_start && status.query_walk);

   // Leaf total and build flag.
   always_comb begin
      n_in     = n_ff;
      built_in = built_ff;
      if (cmd.load) begin
         built_in = 1'b0;
         if (load_ok) n_in = NW'(load_idx + NW'(1));
      end
      if (cmd.set_built) built_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff     <= '0;
         built_ff <= 1'b0;
      end else begin
         n_ff     <= n_in;
         built_ff <= built_in;
      end
   end

   // Queue pointers and first-child weight.
   always_comb begin
      lf_left_in = lf_left_ff;
      nd_rel_in  = nd_rel_ff;
      i_rel_in   = i_rel_ff;
      pick_w_in  = pick_w_ff;
      if (cmd.build_init) begin
         lf_left_in = n_ff;
         nd_rel_in  = '0;
         i_rel_in   = '0;
      end
      if (cmd.pick) begin
         if (take_leaf) lf_left_in = lf_left_ff - NW'(1);
         else nd_rel_in = nd_rel_ff + LW'(1);
         if (cmd.pick_second) i_rel_in = i_rel_ff + LW'(1);
         else pick_w_in = pick_w;
      end
   end

   // Walk step counter and the captured step.
   always_comb begin
      steps_in = steps_ff;
      depth_in = depth_ff;
      pnode_in = pnode_ff;
      pcode_in = pcode_ff;
      found_in = found_ff;
      if (cmd.query_start) begin
         steps_in = '0;
         depth_in = req_depth;
         pnode_in = '0;
         pcode_in = 1'b0;
         found_in = 1'b0;
      end
      if (cmd.walk) begin
         if (step_hit) begin
            pnode_in = pnode_ext[PNODE_W-1:0];
            pcode_in = walk_code;
            found_in = 1'b1;
         end
         steps_in = steps_ff + NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      lf_left_ff <= lf_left_in;
      nd_rel_ff  <= nd_rel_in;
      i_rel_ff   <= i_rel_in;
      pick_w_ff  <= pick_w_in;
      steps_ff   <= steps_in;
      depth_ff   <= depth_in;
      pnode_ff   <= pnode_in;
      pcode_ff   <= pcode_in;
      found_ff   <= found_in;
   end

   // Leaf count memory: written by loads, read at the leaf queue head.
   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) leaf_mem[load_idx[LW-1:0]] <= req_leaf_count;
      if (cmd.fetch) leaf_rd_ff <= leaf_mem[lf_id[LW-1:0]];
   end

   // Internal weight memory: written per finished node, read at the node queue head.
   always_ff @(posedge clock) begin
      if (cmd.pick_second) int_mem[i_rel_ff] <= sum_sat;
      if (cmd.fetch) int_rd_ff <= int_mem[nd_rel_ff];
   end

   // Parent memory: each pick links a child to the node being built.
   always_ff @(posedge clock) begin
      if (cmd.pick) parent_mem[pick_id] <= {cmd.pick_second, node_id};
      if (parent_rd_en) parent_rd_ff <= parent_mem[parent_addr];
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_path_node_ff   <= pnode_ff;
         rsp_code_bit_ff    <= pcode_ff;
         rsp_path_length_ff <= steps_ext[LEN_W-1:0];
         rsp_depth_ok_ff    <= found_ff;
      end
   end

   assign rsp_path_node   = rsp_path_node_ff;
   assign rsp_code_bit    = rsp_code_bit_ff;
   assign rsp_path_length = rsp_path_length_ff;
   assign rsp_depth_ok    = rsp_depth_ok_ff;

   // After the last merge every leaf is used and all but the root were consumed.
   `HTB_ASSERT_NEXT(a_build_drains_queues, clock, reset, cmd.pick_second && status.last_node, (lf_left_ff == '0) && (nd_rel_ff + LW'(1) == i_rel_ff))
   // The node queue never runs ahead of the node under construction.
   `HTB_ASSERT_IMPLY(a_node_queue_behind, clock, reset, cmd.pick, nd_rel_ff <= i_rel_ff)
   // A walk climbs through internal nodes only and stays shorter than the leaf total.
   `HTB_ASSERT_IMPLY(a_walk_within_tree, clock, reset, cmd.walk, (steps_ff < n_ff) && (walk_p >= n_ff))

endmodule

// ===== rtl/core/huffman_tree_builder.sv =====
// Huffman tree builder top level (depends on htb_pkg, htb_req_if, htb_rsp_if, htb_ctrl, htb_dp).
// Load transactions (cmd 0) store one leaf count per cycle while idle, up to MAX_LEAVES;
// the user must give them in descending order, which the block itself does not enforce.
// A load after a finished build starts a new set. The load marked last starts the two-queue
// merge if two or more leaves are held: per child of each internal node, the heads of the
// leaf and node queues are read from their memories and then compared. A query transaction
// (cmd 1) on a built tree walks from the leaf toward the root, one parent-memory read per
// step; its response sits in an output register so that the next transaction is taken while
// the response waits. No transaction is accepted while a build or walk is in progress.
module huffman_tree_builder import htb_pkg::*; #(
   parameter int MAX_LEAVES = 256
) (
   input logic        clock,
   input logic        reset,
   htb_req_if.sink    req_chan,
   htb_rsp_if.source  rsp_chan
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // Sequencing.
   htb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_cmd   (req_chan.cmd),
      .req_last  (req_chan.last),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .status    (status),
      .cmd       (cmd)
   );

   // Storage, merge and walk.
   htb_dp #(
      .MAX_LEAVES (MAX_LEAVES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_leaf_count  (req_chan.leaf_count),
      .req_leaf        (req_chan.leaf),
      .req_depth       (req_chan.depth),
      .rsp_path_node   (rsp_chan.path_node),
      .rsp_code_bit    (rsp_chan.code_bit),
      .rsp_path_length (rsp_chan.path_length),
      .rsp_depth_ok    (rsp_chan.depth_ok)
   );

endmodule
